### rtl/complex_arith_unit_macros.svh
// Assertion helpers for the complex arithmetic unit.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define CAU_ASSERT_IMPLY(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define CAU_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cau_pkg.sv
package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;
    localparam int KIND_W     = 4;
    localparam int DW         = DATA_WIDTH;
    localparam int PROD_W     = 2 * DW;
    localparam int SUM_W      = PROD_W + 1;
    localparam int DEN_W      = PROD_W;
    localparam int WIDE_W     = PROD_W + 2;
    localparam int SHIFT      = DW - FRAC_BITS;
    localparam int DIV_STEPS  = DW;

    typedef enum logic [KIND_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_CONJ = 4'd4,
        OP_NEG  = 4'd5,
        OP_EQ   = 4'd6,
        OP_GT   = 4'd7,
        OP_LT   = 4'd8
    } cau_kind_t;

    typedef struct packed {
        logic signed [DW-1:0] val;
        logic                 sat;
    } cau_clamp_t;

    // Result of the operations that finish before the divider
    typedef struct packed {
        logic signed [DW-1:0] res_re;
        logic signed [DW-1:0] res_im;
        logic                 truth;
        logic                 sat;
    } cau_res_t;

    // Item state while it walks through the divider stages
    typedef struct packed {
        logic             is_div;
        logic             zdiv;
        logic             ovf_re;
        logic             ovf_im;
        logic             neg_re;
        logic             neg_im;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem_re;
        logic [DEN_W-1:0] rem_im;
        logic [DW-1:0]    q_re;
        logic [DW-1:0]    q_im;
        cau_res_t         res;
    } cau_work_t;

    // Saturate a wide signed value to the data range
    function automatic cau_clamp_t clamp_w(input logic signed [WIDE_W-1:0] v);
        cau_clamp_t r;
        logic signed [WIDE_W-1:0] maxv;
        logic signed [WIDE_W-1:0] minv;
        maxv = WIDE_W'({1'b0, {(DW-1){1'b1}}});
        minv = -maxv - WIDE_W'(1);
        if (v > maxv)
        begin
            r.val = {1'b0, {(DW-1){1'b1}}};
            r.sat = 1'b1;
        end
        else if (v < minv)
        begin
            r.val = {1'b1, {(DW-1){1'b0}}};
            r.sat = 1'b1;
        end
        else
        begin
            r.val = DW'(v);
            r.sat = 1'b0;
        end
        return r;
    endfunction

    // Apply sign to a quotient magnitude and saturate
    function automatic cau_clamp_t quot_lane(input logic neg, input logic ovf,
                                             input logic [DW-1:0] q);
        cau_clamp_t r;
        logic signed [WIDE_W-1:0] v;
        v = neg ? -$signed(WIDE_W'(q)) : $signed(WIDE_W'(q));
        r = clamp_w(v);
        if (ovf)
        begin
            r.val = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            r.sat = 1'b1;
        end
        return r;
    endfunction

endpackage

### rtl/cau_in_if.sv
interface cau_in_if import cau_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;

    modport source (output valid, kind, a_re, a_im, b_re, b_im, input ready);
    modport sink (input valid, kind, a_re, a_im, b_re, b_im, output ready);
endinterface

### rtl/cau_out_if.sv
interface cau_out_if import cau_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic                 truth;
    logic                 zero_divisor;
    logic                 saturated;

    modport source (output valid, res_re, res_im, truth, zero_divisor, saturated,
                    input ready);
    modport sink (input valid, res_re, res_im, truth, zero_divisor, saturated,
                  output ready);
endinterface

### rtl/cau_front.sv
module cau_front import cau_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 vld,
    input  logic [KIND_W-1:0]    kind,
    input  logic signed [DW-1:0] a_re,
    input  logic signed [DW-1:0] a_im,
    input  logic signed [DW-1:0] b_re,
    input  logic signed [DW-1:0] b_im,
    output logic                 out_vld,
    output cau_work_t            out_work
);

    // Stage 1: operand registers
    logic                 s1_vld_reg;
    logic [KIND_W-1:0]    s1_kind_reg;
    logic signed [DW-1:0] s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;

    // Stage 2: products and simple results
    logic                     s2_vld_reg;
    logic [KIND_W-1:0]        s2_kind_reg;
    logic signed [PROD_W-1:0] s2_rr_reg, s2_ii_reg, s2_ri_reg, s2_ir_reg;
    logic signed [PROD_W-1:0] s2_aa_reg, s2_aa2_reg, s2_bb_reg, s2_bb2_reg;
    cau_res_t                 s2_res_reg, s2_res_next;

    // Stage 3: sums
    logic                    s3_vld_reg;
    logic [KIND_W-1:0]       s3_kind_reg;
    logic signed [SUM_W-1:0] s3_mre_reg, s3_mim_reg, s3_dre_reg, s3_dim_reg;
    logic [DEN_W-1:0]        s3_ma_reg, s3_mb_reg;
    cau_res_t                s3_res_reg;

    // Stage 4: scaling, compare and divider set-up
    logic      s4_vld_reg;
    cau_work_t s4_work_reg, s4_work_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    // Work out add, sub, conj, negate and equality
    always_comb
    begin
        cau_clamp_t cr;
        cau_clamp_t ci;
        s2_res_next = '0;
        cr = '0;
        ci = '0;
        case (cau_kind_t'(s1_kind_reg))
            OP_ADD:
            begin
                cr = clamp_w(WIDE_W'(s1_ar_reg) + WIDE_W'(s1_br_reg));
                ci = clamp_w(WIDE_W'(s1_ai_reg) + WIDE_W'(s1_bi_reg));
            end
            OP_SUB:
            begin
                cr = clamp_w(WIDE_W'(s1_ar_reg) - WIDE_W'(s1_br_reg));
                ci = clamp_w(WIDE_W'(s1_ai_reg) - WIDE_W'(s1_bi_reg));
            end
            OP_CONJ:
            begin
                cr.val = s1_ar_reg;
                ci = clamp_w(-WIDE_W'(s1_ai_reg));
            end
            OP_NEG:
            begin
                cr = clamp_w(-WIDE_W'(s1_ar_reg));
                ci = clamp_w(-WIDE_W'(s1_ai_reg));
            end
            OP_EQ:
                s2_res_next.truth = (s1_ar_reg == s1_br_reg) && (s1_ai_reg == s1_bi_reg);
            default:
                ;
        endcase
        s2_res_next.res_re = cr.val;
        s2_res_next.res_im = ci.val;
        s2_res_next.sat    = cr.sat | ci.sat;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg <= kind;
            s1_ar_reg   <= a_re;
            s1_ai_reg   <= a_im;
            s1_br_reg   <= b_re;
            s1_bi_reg   <= b_im;

            s2_kind_reg <= s1_kind_reg;
            s2_rr_reg   <= PROD_W'(s1_ar_reg) * PROD_W'(s1_br_reg);
            s2_ii_reg   <= PROD_W'(s1_ai_reg) * PROD_W'(s1_bi_reg);
            s2_ri_reg   <= PROD_W'(s1_ar_reg) * PROD_W'(s1_bi_reg);
            s2_ir_reg   <= PROD_W'(s1_ai_reg) * PROD_W'(s1_br_reg);
            s2_aa_reg   <= PROD_W'(s1_ar_reg) * PROD_W'(s1_ar_reg);
            s2_aa2_reg  <= PROD_W'(s1_ai_reg) * PROD_W'(s1_ai_reg);
            s2_bb_reg   <= PROD_W'(s1_br_reg) * PROD_W'(s1_br_reg);
            s2_bb2_reg  <= PROD_W'(s1_bi_reg) * PROD_W'(s1_bi_reg);
            s2_res_reg  <= s2_res_next;

            s3_kind_reg <= s2_kind_reg;
            s3_mre_reg  <= SUM_W'(s2_rr_reg) - SUM_W'(s2_ii_reg);
            s3_mim_reg  <= SUM_W'(s2_ri_reg) + SUM_W'(s2_ir_reg);
            s3_dre_reg  <= SUM_W'(s2_rr_reg) + SUM_W'(s2_ii_reg);
            s3_dim_reg  <= SUM_W'(s2_ir_reg) - SUM_W'(s2_ri_reg);
            s3_ma_reg   <= DEN_W'(s2_aa_reg) + DEN_W'(s2_aa2_reg);
            s3_mb_reg   <= DEN_W'(s2_bb_reg) + DEN_W'(s2_bb2_reg);
            s3_res_reg  <= s2_res_reg;

            s4_work_reg <= s4_work_next;
        end
    end

    // Floor-scale the product, compare magnitudes, prime the divider
    always_comb
    begin
        cau_clamp_t       cr;
        cau_clamp_t       ci;
        logic [DEN_W-1:0] mag_re;
        logic [DEN_W-1:0] mag_im;
        cr = clamp_w(WIDE_W'(s3_mre_reg >>> FRAC_BITS));
        ci = clamp_w(WIDE_W'(s3_mim_reg >>> FRAC_BITS));
        mag_re = s3_dre_reg[SUM_W-1] ? DEN_W'(-s3_dre_reg) : DEN_W'(s3_dre_reg);
        mag_im = s3_dim_reg[SUM_W-1] ? DEN_W'(-s3_dim_reg) : DEN_W'(s3_dim_reg);

        s4_work_next        = '0;
        s4_work_next.res    = s3_res_reg;
        s4_work_next.den    = s3_mb_reg;
        s4_work_next.zdiv   = (s3_mb_reg == '0);
        s4_work_next.neg_re = s3_dre_reg[SUM_W-1];
        s4_work_next.neg_im = s3_dim_reg[SUM_W-1];
        s4_work_next.ovf_re = (DEN_W+SHIFT)'(mag_re) >= {s3_mb_reg, {SHIFT{1'b0}}};
        s4_work_next.ovf_im = (DEN_W+SHIFT)'(mag_im) >= {s3_mb_reg, {SHIFT{1'b0}}};
        s4_work_next.rem_re = mag_re >> SHIFT;
        s4_work_next.rem_im = mag_im >> SHIFT;
        s4_work_next.q_re   = DW'(mag_re << FRAC_BITS);
        s4_work_next.q_im   = DW'(mag_im << FRAC_BITS);

        case (cau_kind_t'(s3_kind_reg))
            OP_MUL:
            begin
                s4_work_next.res.res_re = cr.val;
                s4_work_next.res.res_im = ci.val;
                s4_work_next.res.sat    = cr.sat | ci.sat;
            end
            OP_DIV:
                s4_work_next.is_div = 1'b1;
            OP_GT:
                s4_work_next.res.truth = s3_ma_reg > s3_mb_reg;
            OP_LT:
                s4_work_next.res.truth = s3_ma_reg < s3_mb_reg;
            default:
                ;
        endcase
    end

    assign out_vld  = s4_vld_reg;
    assign out_work = s4_work_reg;

endmodule

### rtl/cau_div_stage.sv
module cau_div_stage import cau_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      in_vld,
    input  cau_work_t in_work,
    output logic      out_vld,
    output cau_work_t out_work
);

    logic      vld_reg;
    cau_work_t work_reg, work_next;

    // One restoring step on both lanes against the shared divisor
    always_comb
    begin
        logic [DEN_W:0] t_re;
        logic [DEN_W:0] t_im;
        logic [DEN_W:0] d;
        logic           ge_re;
        logic           ge_im;
        d     = {1'b0, in_work.den};
        t_re  = {in_work.rem_re, in_work.q_re[DW-1]};
        t_im  = {in_work.rem_im, in_work.q_im[DW-1]};
        ge_re = t_re >= d;
        ge_im = t_im >= d;
        work_next        = in_work;
        work_next.rem_re = ge_re ? DEN_W'(t_re - d) : DEN_W'(t_re);
        work_next.rem_im = ge_im ? DEN_W'(t_im - d) : DEN_W'(t_im);
        work_next.q_re   = {in_work.q_re[DW-2:0], ge_re};
        work_next.q_im   = {in_work.q_im[DW-2:0], ge_im};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            work_reg <= work_next;
    end

    assign out_vld  = vld_reg;
    assign out_work = work_reg;

endmodule

### rtl/complex_arith_unit.sv
// Complex arithmetic unit on signed Q4.12 operands.
// in_ch carries an operation kind and operands a and b; out_ch returns one
// result per item, in order: res_re, res_im, truth, zero_divisor, saturated.
// Kinds: add, sub, mul, div, conj a, negate a, equal, greater and less by
// squared magnitude; unknown kinds give an all-zero result.
// There are 21 register stages: four front stages (operands, products, sums,
// scaling and divider set-up), sixteen restoring divider stages of one
// quotient bit each, one output stage. Throughput is one item per cycle
// while out_ch takes its results; every operation takes the same path.
// The pipeline advances as one: when out_ch holds a result that is not taken,
// all stages hold and in_ch.ready drops, so nothing is lost or repeated.
// Reset clears every valid bit; the unit takes items in the first cycle after.
module complex_arith_unit import cau_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    cau_in_if.sink    in_ch,
    cau_out_if.source out_ch
);

`include "complex_arith_unit_macros.svh"

    logic      adv;
    logic      fr_vld;
    cau_work_t fr_work;
    logic      dv [0:DIV_STEPS];
    cau_work_t dw [0:DIV_STEPS];

    logic                 out_vld_reg;
    logic signed [DW-1:0] out_re_reg, out_im_reg;
    logic                 out_truth_reg, out_zdiv_reg, out_sat_reg;
    cau_res_t             fin_next;
    logic                 fin_zdiv_next;

    // Advance the whole pipeline unless the output is held
    assign adv         = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = adv;

    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vld      (in_ch.valid),
        .kind     (in_ch.kind),
        .a_re     (in_ch.a_re),
        .a_im     (in_ch.a_im),
        .b_re     (in_ch.b_re),
        .b_im     (in_ch.b_im),
        .out_vld  (fr_vld),
        .out_work (fr_work)
    );

    assign dv[0] = fr_vld;
    assign dw[0] = fr_work;

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        cau_div_stage u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .in_vld   (dv[i]),
            .in_work  (dw[i]),
            .out_vld  (dv[i+1]),
            .out_work (dw[i+1])
        );
    end

    // Sign and saturate quotients, zero the result on a zero divisor, or pass the earlier result
    always_comb
    begin
        cau_clamp_t qr;
        cau_clamp_t qi;
        qr = quot_lane(dw[DIV_STEPS].neg_re, dw[DIV_STEPS].ovf_re, dw[DIV_STEPS].q_re);
        qi = quot_lane(dw[DIV_STEPS].neg_im, dw[DIV_STEPS].ovf_im, dw[DIV_STEPS].q_im);
        fin_next      = dw[DIV_STEPS].res;
        fin_zdiv_next = 1'b0;
        if (dw[DIV_STEPS].is_div)
        begin
            if (dw[DIV_STEPS].zdiv)
            begin
                fin_next      = '0;
                fin_zdiv_next = 1'b1;
            end
            else
            begin
                fin_next.res_re = qr.val;
                fin_next.res_im = qi.val;
                fin_next.truth  = 1'b0;
                fin_next.sat    = qr.sat | qi.sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= dv[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_re_reg    <= fin_next.res_re;
            out_im_reg    <= fin_next.res_im;
            out_truth_reg <= fin_next.truth;
            out_zdiv_reg  <= fin_zdiv_next;
            out_sat_reg   <= fin_next.sat;
        end
    end

    assign out_ch.valid        = out_vld_reg;
    assign out_ch.res_re       = out_re_reg;
    assign out_ch.res_im       = out_im_reg;
    assign out_ch.truth        = out_truth_reg;
    assign out_ch.zero_divisor = out_zdiv_reg;
    assign out_ch.saturated    = out_sat_reg;

    `CAU_ASSERT_IMPLY(a_zdiv_zero, out_vld_reg && out_zdiv_reg,
        out_re_reg == '0 && out_im_reg == '0 && !out_sat_reg && !out_truth_reg,
        "zero divisor result not clean")
    `CAU_ASSERT_IMPLY(a_truth_zero, out_vld_reg && out_truth_reg,
        out_re_reg == '0 && out_im_reg == '0 && !out_sat_reg,
        "compare result carries arithmetic data")
    `CAU_ASSERT_NEXT(a_hold_pipe, out_vld_reg && !out_ch.ready && dv[DIV_STEPS],
        dv[DIV_STEPS] && out_vld_reg, "pipeline moved during stall")

endmodule
